// File: hdl/rcpwm_pkg.sv
// Shared types and constants for the RC PWM throttle decoder.
package rcpwm_pkg;

	localparam int CNT_W = 16;
	localparam int WID_W = CNT_W + 1;
	localparam int THR_W = 14;
	localparam int NUM_W = 30;
	localparam int CFG_W = 16;
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
	localparam int DIV_CNT_W = $clog2(NUM_W);

	localparam logic [THR_W-1:0] FULL_SCALE = THR_W'(10000);
	localparam logic [CNT_W-1:0] NEUTRAL_WIDTH = CNT_W'(1500);

	localparam logic [1:0] LINK_DISCONNECTED = 2'd0;
	localparam logic [1:0] LINK_CONNECTED = 2'd1;
	localparam logic [1:0] LINK_LOST = 2'd2;

	localparam logic [1:0] CFG_PULSE_MIN = 2'd0;
	localparam logic [1:0] CFG_PULSE_MAX = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT = 2'd2;

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_RISE,
		CMD_FALL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [WID_W-1:0] width;
	} cmd_t;

	typedef struct packed {
		logic [CFG_W-1:0] pulse_min;
		logic [CFG_W-1:0] pulse_max;
		logic [CFG_W-1:0] timeout_ms;
	} cfg_t;

endpackage

// File: hdl/rcpwm_front.sv
// Front part: tracks the edge phase and turns each item into a command.
module rcpwm_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       op,
	input  logic [15:0]                capture_value,
	output rcpwm_pkg::cmd_t            cmd
);

	logic                          await_fall_q;
	logic [rcpwm_pkg::CNT_W-1:0]   rise_q;
	logic [rcpwm_pkg::CNT_W-1:0]   cap;
	logic [rcpwm_pkg::WID_W-1:0]   width;

	assign cap = capture_value[rcpwm_pkg::CNT_W-1:0];

	always_comb begin
		if (cap > rise_q) begin
			width = {1'b0, cap} - {1'b0, rise_q};
		end else begin
			width = {1'b1, cap} - {1'b0, rise_q};
		end
		cmd.width = width;
		if (op == rcpwm_pkg::OP_TICK) begin
			cmd.kind = rcpwm_pkg::CMD_TICK;
		end else if (await_fall_q) begin
			cmd.kind = rcpwm_pkg::CMD_FALL;
		end else begin
			cmd.kind = rcpwm_pkg::CMD_RISE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_fall_q <= 1'b0;
			rise_q <= '0;
		end else if (accept && op == rcpwm_pkg::OP_EDGE) begin
			await_fall_q <= !await_fall_q;
			if (!await_fall_q) begin
				rise_q <= cap;
			end
		end
	end

endmodule

// File: hdl/rcpwm_cmd_fifo.sv
// Short command queue between the front and back parts.
module rcpwm_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  rcpwm_pkg::cmd_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output rcpwm_pkg::cmd_t rd_data,
	output logic            empty
);

	rcpwm_pkg::cmd_t                    mem_q [rcpwm_pkg::CMDQ_DEPTH];
	logic [rcpwm_pkg::CMDQ_PTR_W-1:0]   wr_ptr_q;
	logic [rcpwm_pkg::CMDQ_PTR_W-1:0]   rd_ptr_q;
	logic [rcpwm_pkg::CMDQ_CNT_W-1:0]   count_q;
	logic                               do_wr;
	logic                               do_rd;

	assign full = count_q == rcpwm_pkg::CMDQ_CNT_W'(rcpwm_pkg::CMDQ_DEPTH);
	assign empty = count_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/rcpwm_divider.sv
// Restoring serial divider, one quotient bit per cycle.
module rcpwm_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rcpwm_pkg::NUM_W-1:0]   numer,
	input  logic [rcpwm_pkg::CFG_W-1:0]   denom,
	output logic                          done,
	output logic [rcpwm_pkg::THR_W-1:0]   quot
);

	logic                                 busy_q;
	logic                                 done_q;
	logic [rcpwm_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [rcpwm_pkg::NUM_W-1:0]          num_q;
	logic [rcpwm_pkg::CFG_W-1:0]          rem_q;
	logic [rcpwm_pkg::CFG_W-1:0]          den_q;
	logic [rcpwm_pkg::CFG_W:0]            rem_shift;
	logic                                 fits;

	assign rem_shift = {rem_q, num_q[rcpwm_pkg::NUM_W-1]};
	assign fits = rem_shift >= {1'b0, den_q};
	assign done = done_q;
	assign quot = num_q[rcpwm_pkg::THR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= rcpwm_pkg::DIV_CNT_W'(rcpwm_pkg::NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			num_q <= {num_q[rcpwm_pkg::NUM_W-2:0], fits};
			if (fits) begin
				rem_q <= rcpwm_pkg::CFG_W'(rem_shift - {1'b0, den_q});
			end else begin
				rem_q <= rem_shift[rcpwm_pkg::CFG_W-1:0];
			end
		end
	end

endmodule

// File: hdl/rcpwm_back.sv
// Back part: link state, timeout, throttle computation and the result register.
module rcpwm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcpwm_pkg::cfg_t               cfg,
	input  logic                          cmd_empty,
	input  rcpwm_pkg::cmd_t               cmd,
	output logic                          cmd_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic [1:0]                    link_state,
	output logic                          signal_valid,
	output logic [15:0]                   pulse_width,
	output logic [13:0]                   throttle_hundredths,
	output logic                          pulse_accepted
);

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	state_t                            state_q;
	logic [rcpwm_pkg::CFG_W-1:0]       elapsed_q;
	logic [1:0]                        link_q;
	logic                              valid_q;
	logic [rcpwm_pkg::CNT_W-1:0]       held_q;
	logic [rcpwm_pkg::THR_W-1:0]       thr_q;

	logic                              res_valid_q;
	logic [1:0]                        res_link_q;
	logic                              res_sig_q;
	logic [rcpwm_pkg::CNT_W-1:0]       res_width_q;
	logic [rcpwm_pkg::THR_W-1:0]       res_thr_q;
	logic                              res_acc_q;

	logic [rcpwm_pkg::CFG_W-1:0]       elapsed_inc;
	logic [rcpwm_pkg::CFG_W-1:0]       n_elapsed;
	logic [1:0]                        n_link;
	logic                              n_valid;
	logic [rcpwm_pkg::CNT_W-1:0]       n_held;
	logic [rcpwm_pkg::THR_W-1:0]       n_thr;
	logic                              n_acc;
	logic [rcpwm_pkg::THR_W-1:0]       n_report;
	logic                              span_ok;
	logic                              in_range;
	logic                              issue;
	logic                              div_start;
	logic                              div_done;
	logic [rcpwm_pkg::CNT_W-1:0]       diff;
	logic [rcpwm_pkg::NUM_W-1:0]       numer;
	logic [rcpwm_pkg::CFG_W-1:0]       span;
	logic [rcpwm_pkg::THR_W-1:0]       quot;

	assign span_ok = cfg.pulse_max > cfg.pulse_min;
	assign span = cfg.pulse_max - cfg.pulse_min;
	assign in_range = cmd.width >= {1'b0, cfg.pulse_min} && cmd.width <= {1'b0, cfg.pulse_max};
	assign issue = state_q == ST_IDLE && !cmd_empty && (!res_valid_q || pop);
	assign cmd_pop = issue;
	assign div_start = issue && n_acc && span_ok;
	assign diff = cmd.width[rcpwm_pkg::CNT_W-1:0] - cfg.pulse_min;
	assign numer = rcpwm_pkg::NUM_W'(diff) * rcpwm_pkg::NUM_W'(rcpwm_pkg::FULL_SCALE);
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		n_elapsed = elapsed_q;
		n_link = link_q;
		n_valid = valid_q;
		n_held = held_q;
		n_thr = thr_q;
		n_acc = 1'b0;
		case (cmd.kind)
			rcpwm_pkg::CMD_TICK: begin
				n_elapsed = elapsed_inc;
				if (elapsed_inc > cfg.timeout_ms) begin
					n_link = rcpwm_pkg::LINK_LOST;
					n_valid = 1'b0;
					n_thr = '0;
				end
			end
			rcpwm_pkg::CMD_FALL: begin
				if (in_range) begin
					n_held = cmd.width[rcpwm_pkg::CNT_W-1:0];
					n_elapsed = '0;
					n_valid = 1'b1;
					n_link = rcpwm_pkg::LINK_CONNECTED;
					n_thr = '0;
					n_acc = 1'b1;
				end
			end
			default: begin
			end
		endcase
		n_report = (n_valid && span_ok) ? n_thr : '0;
	end

	rcpwm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (numer),
		.denom  (span),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			elapsed_q <= '0;
			link_q <= rcpwm_pkg::LINK_DISCONNECTED;
			valid_q <= 1'b0;
			held_q <= rcpwm_pkg::NEUTRAL_WIDTH;
			thr_q <= '0;
			res_valid_q <= 1'b0;
			res_link_q <= rcpwm_pkg::LINK_DISCONNECTED;
			res_sig_q <= 1'b0;
			res_width_q <= '0;
			res_thr_q <= '0;
			res_acc_q <= 1'b0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (issue) begin
						elapsed_q <= n_elapsed;
						link_q <= n_link;
						valid_q <= n_valid;
						held_q <= n_held;
						thr_q <= n_thr;
						if (div_start) begin
							state_q <= ST_DIV;
						end else begin
							res_valid_q <= 1'b1;
							res_link_q <= n_link;
							res_sig_q <= n_valid;
							res_width_q <= n_held;
							res_thr_q <= n_report;
							res_acc_q <= n_acc;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						thr_q <= quot;
						res_valid_q <= 1'b1;
						res_link_q <= link_q;
						res_sig_q <= valid_q;
						res_width_q <= held_q;
						res_thr_q <= quot;
						res_acc_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty = !res_valid_q;
	assign link_state = res_link_q;
	assign signal_valid = res_sig_q;
	assign pulse_width = res_width_q;
	assign throttle_hundredths = res_thr_q;
	assign pulse_accepted = res_acc_q;

endmodule

// File: hdl/rc_pwm_throttle_decoder.sv
// Top level of the RC PWM throttle decoder with its configuration registers.
//
// Items enter through push/full: op selects a capture edge (0) or a one
// millisecond tick (1), and capture_value carries the timer count of an edge.
// Each item yields exactly one result, read through empty/pop: the link state,
// the valid flag, the last accepted pulse width, the throttle in hundredths of
// a percent and a flag for a pulse accepted by this item.
// A result passes through the command queue and the result register. A falling
// edge that gives an accepted width while pulse_max is above pulse_min goes
// through the serial divider, which produces one quotient bit per cycle over a
// 30-bit numerator. Other items finish from the idle state of the back part.
// A two-entry command queue sits between the edge tracking front and the back,
// so edges and ticks are taken while the divider runs or a result waits.
// When the receiver does not pop, the result register holds, the back part
// stops, the queue fills and full rises.
// Reset restores the default bounds 1000 to 2000 counts, a 100 ms timeout,
// the disconnected state and a held width of 1500 counts. The user must write
// registers via cfg_we, cfg_index and cfg_data only while idle: no interlock.
module rc_pwm_throttle_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [15:0] capture_value,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  link_state,
	output logic        signal_valid,
	output logic [15:0] pulse_width,
	output logic [13:0] throttle_hundredths,
	output logic        pulse_accepted,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	rcpwm_pkg::cfg_t cfg_q;
	rcpwm_pkg::cmd_t front_cmd;
	rcpwm_pkg::cmd_t back_cmd;
	logic            accept;
	logic            cmd_empty;
	logic            cmd_pop;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_min <= 16'd1000;
			cfg_q.pulse_max <= 16'd2000;
			cfg_q.timeout_ms <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				rcpwm_pkg::CFG_PULSE_MIN: cfg_q.pulse_min <= cfg_data;
				rcpwm_pkg::CFG_PULSE_MAX: cfg_q.pulse_max <= cfg_data;
				rcpwm_pkg::CFG_TIMEOUT: cfg_q.timeout_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rcpwm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.op            (op),
		.capture_value (capture_value),
		.cmd           (front_cmd)
	);

	rcpwm_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_cmd),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (back_cmd),
		.empty   (cmd_empty)
	);

	rcpwm_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg                 (cfg_q),
		.cmd_empty           (cmd_empty),
		.cmd                 (back_cmd),
		.cmd_pop             (cmd_pop),
		.pop                 (pop),
		.empty               (empty),
		.link_state          (link_state),
		.signal_valid        (signal_valid),
		.pulse_width         (pulse_width),
		.throttle_hundredths (throttle_hundredths),
		.pulse_accepted      (pulse_accepted)
	);

endmodule

// File: verif/rc_pwm_throttle_decoder_tb.sv
// Self-checking testbench for the RC PWM throttle decoder.
`timescale 1ns / 1ps

module rc_pwm_throttle_decoder_tb;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS = 40;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic        op;
		logic [15:0] capture;
	} edge_item_t;

	typedef struct {
		logic [1:0]  link;
		logic        valid;
		logic [15:0] width;
		logic [13:0] throttle;
		logic        accepted;
	} reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        op = rcpwm_pkg::OP_EDGE;
	logic [15:0] capture_value = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  link_state;
	logic        signal_valid;
	logic [15:0] pulse_width;
	logic [13:0] throttle_hundredths;
	logic        pulse_accepted;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = rcpwm_pkg::CFG_PULSE_MIN;
	logic [15:0] cfg_data = '0;

	rc_pwm_throttle_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.op(op),
		.capture_value(capture_value),
		.empty(empty),
		.pop(pop),
		.link_state(link_state),
		.signal_valid(signal_valid),
		.pulse_width(pulse_width),
		.throttle_hundredths(throttle_hundredths),
		.pulse_accepted(pulse_accepted),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	edge_item_t pending_items[$];
	reading_t   expected_readings[$];

	// Decoder state as the testbench sees it.
	logic [15:0] bound_lo = 16'd1000;
	logic [15:0] bound_hi = 16'd2000;
	logic [15:0] loss_ms = 16'd100;
	logic        in_pulse = 1'b0;
	logic [15:0] rise_stamp = '0;
	logic [15:0] last_width = rcpwm_pkg::NEUTRAL_WIDTH;
	logic [15:0] ms_since_pulse = '0;
	logic [1:0]  link_now = rcpwm_pkg::LINK_DISCONNECTED;
	logic        valid_now = 1'b0;
	logic [13:0] throttle_now = '0;

	int  errors = 0;
	int  cycles = 0;
	int  queued = 0;
	int  src_wait = 0;
	int  sink_wait = 0;
	bit  src_rush = 1'b0;
	bit  sink_rush = 1'b0;
	bit  gen_half = 1'b0;
	bit  item_taken = 1'b0;
	bit  result_taken = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	function automatic logic [13:0] scale_throttle(input int unsigned w);
		longint unsigned num;
		longint unsigned span;
		if (bound_hi <= bound_lo)
			return '0;
		num = longint'(w - int'(bound_lo)) * longint'(rcpwm_pkg::FULL_SCALE);
		span = longint'(bound_hi) - longint'(bound_lo);
		return 14'(num / span);
	endfunction

	task automatic decode_item(input logic item_op, input logic [15:0] cap);
		int unsigned w;
		reading_t r;
		r.accepted = 1'b0;
		if (item_op == rcpwm_pkg::OP_TICK) begin
			if (ms_since_pulse != 16'hFFFF)
				ms_since_pulse++;
			if (ms_since_pulse > loss_ms) begin
				link_now = rcpwm_pkg::LINK_LOST;
				valid_now = 1'b0;
				throttle_now = '0;
			end
		end else if (!in_pulse) begin
			rise_stamp = cap;
			in_pulse = 1'b1;
		end else begin
			if (cap > rise_stamp)
				w = int'(cap) - int'(rise_stamp);
			else
				w = 65536 + int'(cap) - int'(rise_stamp);
			if (w >= int'(bound_lo) && w <= int'(bound_hi)) begin
				last_width = 16'(w);
				ms_since_pulse = '0;
				valid_now = 1'b1;
				link_now = rcpwm_pkg::LINK_CONNECTED;
				throttle_now = scale_throttle(w);
				r.accepted = 1'b1;
			end
			in_pulse = 1'b0;
		end
		r.link = link_now;
		r.valid = valid_now;
		r.width = last_width;
		r.throttle = (valid_now && bound_hi > bound_lo) ? throttle_now : '0;
		expected_readings.push_back(r);
	endtask

	function automatic int gap_for(input bit rush);
		if (rush)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	// Input side: acceptance and prediction at the rising edge, driving at the falling edge.
	always @(posedge clk) begin
		item_taken <= arst_n && push && !full;
		if (arst_n && push && !full)
			decode_item(op, capture_value);
	end

	always @(negedge clk) begin
		edge_item_t it;
		if (arst_n) begin
			if (push && item_taken) begin
				src_wait = gap_for(src_rush);
				if (src_wait == 0 && pending_items.size() != 0) begin
					it = pending_items.pop_front();
					op <= it.op;
					capture_value <= it.capture;
				end else begin
					push <= 1'b0;
				end
			end else if (!push) begin
				if (src_wait != 0) begin
					src_wait--;
				end else if (pending_items.size() != 0) begin
					it = pending_items.pop_front();
					op <= it.op;
					capture_value <= it.capture;
					push <= 1'b1;
				end
			end
		end
	end

	// Result side.
	always @(negedge clk) begin
		if (arst_n) begin
			if (pop && result_taken) begin
				sink_wait = gap_for(sink_rush);
				if (sink_wait != 0)
					pop <= 1'b0;
			end else if (!pop) begin
				if (sink_wait != 0)
					sink_wait--;
				else
					pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		reading_t r;
		result_taken <= arst_n && pop && !empty;
		if (arst_n && pop && !empty) begin
			if (expected_readings.size() == 0) begin
				report_mismatch("result with no item waiting for it");
			end else begin
				r = expected_readings.pop_front();
				if (link_state !== r.link)
					report_mismatch($sformatf("link_state: expected %0d, got %0d",
						r.link, link_state));
				if (signal_valid !== r.valid)
					report_mismatch($sformatf("signal_valid: expected %0d, got %0d",
						r.valid, signal_valid));
				if (pulse_width !== r.width)
					report_mismatch($sformatf("pulse_width: expected %0d, got %0d",
						r.width, pulse_width));
				if (throttle_hundredths !== r.throttle)
					report_mismatch($sformatf("throttle_hundredths: expected %0d, got %0d",
						r.throttle, throttle_hundredths));
				if (pulse_accepted !== r.accepted)
					report_mismatch($sformatf("pulse_accepted: expected %0d, got %0d",
						r.accepted, pulse_accepted));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic queue_item(input logic item_op, input logic [15:0] cap);
		edge_item_t it;
		it.op = item_op;
		it.capture = cap;
		pending_items.push_back(it);
		queued++;
		if (item_op == rcpwm_pkg::OP_EDGE)
			gen_half = ~gen_half;
	endtask

	task automatic queue_ticks(input int n);
		repeat (n) queue_item(rcpwm_pkg::OP_TICK, 16'($urandom));
	endtask

	// A stray edge left over from noise is paired off first so the pulse lines up.
	task automatic queue_pulse(input logic [15:0] rise, input int w);
		if (gen_half)
			queue_item(rcpwm_pkg::OP_EDGE, 16'($urandom));
		queue_item(rcpwm_pkg::OP_EDGE, rise);
		queue_item(rcpwm_pkg::OP_EDGE, 16'(int'(rise) + w));
	endtask

	task automatic wait_idle;
		while (pending_items.size() != 0 || push || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			rcpwm_pkg::CFG_PULSE_MIN: bound_lo = data;
			rcpwm_pkg::CFG_PULSE_MAX: bound_hi = data;
			rcpwm_pkg::CFG_TIMEOUT: loss_ms = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] tmo);
		write_reg(rcpwm_pkg::CFG_PULSE_MIN, lo);
		write_reg(CFG_UNUSED, 16'($urandom));
		write_reg(rcpwm_pkg::CFG_PULSE_MAX, hi);
		write_reg(rcpwm_pkg::CFG_TIMEOUT, tmo);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] tmo, input int n_items);
		int start;
		int w;
		int burst;
		wait_idle;
		program_regs(lo, hi, tmo);
		src_rush = ($urandom_range(0, 3) == 0);
		sink_rush = ($urandom_range(0, 3) == 0);
		@(posedge clk);
		start = queued;
		while (queued - start < n_items) begin
			case ($urandom_range(0, 19))
				0: queue_item(rcpwm_pkg::OP_EDGE, 16'($urandom));
				1: begin
					burst = (tmo <= 120) ? int'(tmo) + $urandom_range(0, 3)
						: $urandom_range(0, 8);
					queue_ticks(burst);
				end
				default: begin
					queue_ticks($urandom_range(0, 2));
					case ($urandom_range(0, 7))
						0: w = int'(lo);
						1: w = int'(hi);
						2: w = int'(lo) - 1;
						3: w = int'(hi) + 1;
						4, 5: w = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 65535);
						6: w = $urandom_range(1, 65535);
						default: w = 0;
					endcase
					queue_pulse(16'($urandom), w);
				end
			endcase
		end
	endtask

	initial begin
		logic [15:0] lo;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default bounds: one tick must not lose a link that was never made.
		@(posedge clk);
		queue_ticks(1);

		// A timeout with no pulse ever accepted.
		wait_idle;
		write_reg(rcpwm_pkg::CFG_TIMEOUT, 16'd1);
		cfg_we <= 1'b0;
		@(posedge clk);
		queue_ticks(2);

		wait_idle;
		write_reg(rcpwm_pkg::CFG_TIMEOUT, 16'd100);
		cfg_we <= 1'b0;
		@(posedge clk);
		queue_pulse(16'd0, 1000);
		queue_pulse(16'd100, 2000);
		queue_pulse(16'd65000, 1500);
		queue_pulse(16'd5, 999);
		queue_pulse(16'd7, 2001);
		queue_pulse(16'hFFFF, 0);
		queue_pulse(16'h8000, 1234);
		queue_pulse(16'hFFFF, 1001);
		queue_ticks(1);

		// A long run of ticks under the largest timeouts keeps the link.
		wait_idle;
		program_regs(16'd1000, 16'd2000, 16'hFFFF);
		src_rush = 1'b1;
		sink_rush = 1'b1;
		@(posedge clk);
		queue_ticks(150);
		wait_idle;
		write_reg(rcpwm_pkg::CFG_TIMEOUT, 16'hFFFE);
		cfg_we <= 1'b0;
		@(posedge clk);
		queue_ticks(2);
		queue_pulse(16'h1234, 1750);

		run_phase(16'd1000, 16'd2000, 16'd100, 180);
		run_phase(16'd0, 16'hFFFF, 16'hFFFF, 180);
		run_phase(16'd1500, 16'd1500, 16'd5, 180);
		run_phase(16'd2000, 16'd1000, 16'd3, 180);
		run_phase(16'd0, 16'd0, 16'd0, 180);
		run_phase(16'hFFFF, 16'hFFFF, 16'd10, 180);
		run_phase(16'd900, 16'd2100, 16'd20, 180);
		repeat (2) begin
			lo = 16'($urandom_range(0, 60000));
			run_phase(lo, 16'($urandom_range(lo, 65535)), 16'($urandom_range(0, 50)), 180);
		end

		wait_idle;
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/rcpwm_pkg.sv
hdl/rcpwm_front.sv
hdl/rcpwm_cmd_fifo.sv
hdl/rcpwm_divider.sv
hdl/rcpwm_back.sv
hdl/rc_pwm_throttle_decoder.sv
verif/rc_pwm_throttle_decoder_tb.sv
